FILE: sv/deq_pkg.sv
package deq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SPAN_W   = CNT_W + 1;
  localparam int VAL_W    = 32;
  localparam int SUM_W    = 38;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: sv/deq_in_if.sv
interface deq_in_if import deq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

FILE: sv/deq_out_if.sv
interface deq_out_if import deq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OCNT_W-1:0] entry_count;
  logic signed [SUM_W-1:0] value_sum;
  logic [STAT_W-1:0] status;

  modport source (output valid, output entry_count, output value_sum, output status,
                  input ready);
  modport sink   (input valid, input entry_count, input value_sum, input status,
                  output ready);
endinterface

FILE: sv/deq_ram.sv
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  deq_in_if.sink           in_word,
  deq_out_if.source        out_word,
  output ram_req_t         ram_req,
  input  logic [VAL_W-1:0] rd_data
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [SUM_W-1:0]  sum, sum_next;

  cmd_t              cmd_q;
  logic [VAL_W-1:0]  val_q;
  logic [IDX_W-1:0]  slot_q;
  logic [IDX_W-1:0]  slot_sel;

  logic              out_valid;
  logic [CNT_W-1:0]  out_count;
  logic [SUM_W-1:0]  out_sum;
  status_t           out_status;
  status_t           status_next;

  logic              accept, fire, is_ins, full, empty;
  logic [IDX_W-1:0]  front_dec, front_inc;
  logic [SPAN_W-1:0] span_ins, span_rem;
  logic [IDX_W-1:0]  back_ins, back_rem;

  assign accept = in_word.valid && in_word.ready;
  assign fire   = (state == S_EXEC) && (!out_valid || out_word.ready);
  assign is_ins = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  assign front_dec = (front == '0) ? IDX_W'(CAPACITY - 1) : front - 1'b1;
  assign front_inc = (front == IDX_W'(CAPACITY - 1)) ? '0 : front + 1'b1;

  // ring position = front + offset, wrapped once
  assign span_ins = SPAN_W'(front) + SPAN_W'(count);
  assign span_rem = span_ins - 1'b1;
  assign back_ins = (span_ins >= SPAN_W'(CAPACITY)) ?
                    IDX_W'(span_ins - SPAN_W'(CAPACITY)) : IDX_W'(span_ins);
  assign back_rem = (span_rem >= SPAN_W'(CAPACITY)) ?
                    IDX_W'(span_rem - SPAN_W'(CAPACITY)) : IDX_W'(span_rem);

  always_comb begin
    case (cmd_t'(in_word.command))
      CMD_PUSH_FRONT: slot_sel = front_dec;
      CMD_PUSH_BACK:  slot_sel = back_ins;
      CMD_POP_FRONT:  slot_sel = front;
      CMD_POP_BACK:   slot_sel = back_rem;
      default:        slot_sel = front;
    endcase
  end

  assign in_word.ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    sum_next    = sum;
    status_next = STAT_DONE;
    ram_req.we    = 1'b0;
    ram_req.waddr = slot_q;
    ram_req.wdata = val_q;
    ram_req.re    = accept;
    ram_req.raddr = slot_sel;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_ins) begin
          if (full) begin
            status_next = STAT_FULL;
          end else begin
            ram_req.we = fire;
            count_next = count + 1'b1;
            sum_next   = sum + SUM_W'(signed'(val_q));
            if (cmd_q == CMD_PUSH_FRONT) begin
              front_next = slot_q;
            end
          end
        end else begin
          if (empty) begin
            status_next = STAT_EMPTY;
          end else begin
            count_next = count - 1'b1;
            sum_next   = sum - SUM_W'(signed'(rd_data));
            if (cmd_q == CMD_POP_FRONT) begin
              front_next = front_inc;
            end
          end
        end
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        front     <= front_next;
        count     <= count_next;
        sum       <= sum_next;
        out_valid <= 1'b1;
      end else if (out_word.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(in_word.command);
      val_q  <= in_word.value;
      slot_q <= slot_sel;
    end
    if (fire) begin
      out_count  <= count_next;
      out_sum    <= sum_next;
      out_status <= status_next;
    end
  end

  assign out_word.valid       = out_valid;
  assign out_word.entry_count = OCNT_W'(out_count);
  assign out_word.value_sum   = out_sum;
  assign out_word.status      = out_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted word did not enter execute");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (fire && is_ins && !full) |=> (count == $past(count) + 1'b1))
    else $error("insert did not bump count");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (fire && (status_next == STAT_EMPTY)) |-> (empty && !is_ins))
    else $error("empty status on non-empty queue");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state == S_EXEC))
    else $error("store written outside execute");

endmodule

FILE: sv/double_ended_queue_with_sum_unit.sv
// Bounded double-ended queue of CAPACITY signed 32-bit words kept in a ring in one
// single-port-write, registered-read RAM. Each input word carries a command (insert
// front, insert back, remove front, remove back) and returns exactly one result word
// with the entry count, the exact 38-bit running sum and a status (done, refused
// because empty, refused because full). The accept cycle issues the RAM read for the
// slot the item touches; in execute the item uses the read data, updates front pointer,
// count and sum, writes the RAM on inserts and loads the output register once that is
// free or being taken. A new word is taken once that item has moved into the output
// register, so one result may wait there while the next item is taken. Entries need no
// clearing after reset; only stored slots are ever used.
module double_ended_queue_with_sum_unit import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  deq_in_if.sink    in_word,
  deq_out_if.source out_word
);

  ram_req_t         ram_req;
  logic [VAL_W-1:0] rd_data;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .out_word (out_word),
    .ram_req  (ram_req),
    .rd_data  (rd_data)
  );

  deq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

endmodule

FILE: test/double_ended_queue_with_sum_unit_test.sv
module double_ended_queue_with_sum_unit_test;
  import deq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 150;
  localparam int          RANDOM_OPS  = 80;

  typedef struct packed {
    logic [OCNT_W-1:0] count;
    logic [SUM_W-1:0]  sum;
    status_t           status;
  } deq_result_t;

  logic clk;
  logic rst;

  deq_in_if  in_word();
  deq_out_if out_word();

  double_ended_queue_with_sum_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // shadow of the deque
  logic [VAL_W-1:0] shadow_ring [CAPACITY];
  logic [IDX_W-1:0] shadow_head;
  int               shadow_fill;
  logic [SUM_W-1:0] shadow_sum;

  deq_result_t pending_results[$];

  int          mismatches;
  int          results_seen;
  int          empty_refusals;
  int          full_refusals;
  int          peak_fill;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_off;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [SUM_W-1:0] sign_extend(input logic [VAL_W-1:0] data);
    return {{(SUM_W-VAL_W){data[VAL_W-1]}}, data};
  endfunction

  function automatic int draw_wait();
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 1);
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void predict_result(input cmd_t op, input logic [VAL_W-1:0] data);
    deq_result_t      r;
    logic [IDX_W-1:0] slot;
    r.status = STAT_DONE;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_fill == CAPACITY) begin
          r.status = STAT_FULL;
          full_refusals++;
        end else begin
          if (op == CMD_PUSH_FRONT) begin
            shadow_head = shadow_head - 1'b1;
            slot = shadow_head;
          end else begin
            slot = IDX_W'(shadow_head + shadow_fill);
          end
          shadow_ring[slot] = data;
          shadow_fill++;
          shadow_sum = shadow_sum + sign_extend(data);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
          empty_refusals++;
        end else begin
          if (op == CMD_POP_FRONT) begin
            slot = shadow_head;
            shadow_head = shadow_head + 1'b1;
          end else begin
            slot = IDX_W'(shadow_head + shadow_fill - 1);
          end
          shadow_sum = shadow_sum - sign_extend(shadow_ring[slot]);
          shadow_fill--;
        end
      end
      default: ;
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.count = OCNT_W'(shadow_fill);
    r.sum = shadow_sum;
    pending_results.push_back(r);
  endfunction

  task automatic send_word(input cmd_t op, input logic [VAL_W-1:0] data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.command <= op;
    in_word.value <= data;
    do @(posedge clk); while (in_word.ready !== 1'b1);
    predict_result(op, data);
  endtask

  // result side: random stalls, optional long hold-off, check on every accepted word
  initial begin
    int          stall;
    deq_result_t want;
    out_word.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0 || hold_off) begin
        out_word.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_word.ready <= 1'b1;
      do @(posedge clk); while (rst || out_word.valid !== 1'b1);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: count %0d sum %0d status %0d",
                   out_word.entry_count, out_word.value_sum, out_word.status);
      end else begin
        want = pending_results.pop_front();
        if (out_word.entry_count !== want.count || out_word.value_sum !== want.sum ||
            out_word.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: count %0d/%0d sum %0d/%0d status %0d/%0d (exp/got)",
                     want.count, out_word.entry_count, $signed(want.sum),
                     out_word.value_sum, want.status, out_word.status);
        end
      end
    end
  end

  task automatic test_directed_edges;
    send_word(CMD_POP_FRONT, draw_value());
    send_word(CMD_POP_BACK, draw_value());
    send_word(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_word(CMD_PUSH_BACK, 32'h8000_0000);
    send_word(CMD_PUSH_FRONT, '0);
    send_word(CMD_PUSH_BACK, '1);
    send_word(CMD_PUSH_FRONT, 32'h5555_5555);
    send_word(CMD_PUSH_BACK, 32'haaaa_aaaa);
    send_word(CMD_POP_FRONT, draw_value());
    send_word(CMD_POP_BACK, draw_value());
    send_word(CMD_PUSH_BACK, 32'h0000_0001);
    send_word(CMD_POP_BACK, draw_value());
    send_word(CMD_POP_FRONT, draw_value());
    send_word(CMD_POP_BACK, draw_value());
    send_word(CMD_POP_FRONT, draw_value());
    send_word(CMD_POP_BACK, draw_value());
    send_word(CMD_POP_FRONT, draw_value());
    send_word(CMD_POP_BACK, draw_value());
  endtask

  // fill to capacity with extreme words for both sum limits, refuse, then drain
  task automatic test_full_and_drain;
    repeat (CAPACITY) send_word(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_word(CMD_PUSH_FRONT, draw_value());
    send_word(CMD_PUSH_BACK, draw_value());
    for (int n = 0; n < CAPACITY; n++)
      send_word(n[0] ? CMD_POP_BACK : CMD_POP_FRONT, draw_value());
    repeat (CAPACITY) send_word(CMD_PUSH_BACK, 32'h8000_0000);
    send_word(CMD_PUSH_BACK, draw_value());
    send_word(CMD_PUSH_FRONT, draw_value());
    repeat (CAPACITY) send_word(CMD_POP_FRONT, draw_value());
    send_word(CMD_POP_BACK, draw_value());
  endtask

  task automatic test_backpressure;
    quiet = 1'b1;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int n = 0; n < 40; n++)
      send_word(($urandom_range(0, 3) != 0) ? CMD_PUSH_BACK : CMD_POP_FRONT, draw_value());
    quiet = 1'b0;
  endtask

  // phases with a drift toward growing or shrinking so full and empty both recur
  task automatic test_random_traffic;
    int   grow_pct;
    cmd_t op;
    grow_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 20 == 0) begin
        grow_pct = $urandom_range(10, 90);
        quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(1, 100) <= grow_pct)
        op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      send_word(op, draw_value());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    in_word.valid <= 1'b0;
    in_word.command <= CMD_PUSH_FRONT;
    in_word.value <= '0;
    shadow_head = '0;
    shadow_fill = 0;
    shadow_sum = '0;
    mismatches = 0;
    results_seen = 0;
    empty_refusals = 0;
    full_refusals = 0;
    peak_fill = 0;
    cycle_count = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_full_and_drain();
    test_backpressure();
    test_random_traffic();

    in_word.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d result words; %0d empty refusals, %0d full refusals, peak fill %0d",
             results_seen, empty_refusals, full_refusals, peak_fill);
    $display("Covered both ends, capacity limits, extreme sums and a long output stall");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
